// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ===== design/mgh_pkg.sv =====
package mgh_pkg;

   localparam int WINDOW = 15;
   localparam int MEDIAN_IDX = WINDOW / 2;
   localparam int AGE_W = $clog2(WINDOW);

   typedef logic [AGE_W-1:0] age_type;
   typedef logic signed [15:0] sample_type;

   localparam age_type AGE_MAX = AGE_W'(WINDOW - 1);

   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_GAMMA = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;

   localparam logic [15:0] ALPHA_RESET = 16'd26214;
   localparam logic [15:0] GAMMA_RESET = 16'd39322;
   localparam logic [14:0] THRESHOLD_RESET = 15'd8192;

   typedef struct packed {
      logic load;
      logic del;
      logic ins;
      logic mul1;
      logic lvl;
      logic mul2;
      logic upd;
   } ctrl_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] gamma;
      logic [14:0] threshold;
   } coef_type;

   // floor((v + 2^15) / 2^16), round half up
   function automatic logic signed [21:0] round_q16(input logic signed [37:0] v);
      logic signed [37:0] w;
      w = v + 38'sd32768;
      return 22'(w >>> 16);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      if (v > 22'sd32767) begin
         return 16'sh7fff;
      end else if (v < -22'sd32768) begin
         return 16'sh8000;
      end else begin
         return 16'(v);
      end
   endfunction

   function automatic logic signed [17:0] sat18(input logic signed [21:0] v);
      if (v > 22'sd131071) begin
         return 18'sh1ffff;
      end else if (v < -22'sd131072) begin
         return 18'sh20000;
      end else begin
         return 18'(v);
      end
   endfunction

endpackage

// ===== design/mgh_cell.sv =====
module mgh_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  mgh_pkg::ctrl_type    ctrl,
   input  mgh_pkg::age_type     reset_age,
   input  logic                 is_last,
   input  mgh_pkg::sample_type  sample,
   input  mgh_pkg::sample_type  left_val,
   input  mgh_pkg::age_type     left_age,
   input  logic                 shift_left,
   input  logic                 gt_left,
   input  mgh_pkg::sample_type  right_val,
   input  mgh_pkg::age_type     right_age,
   output mgh_pkg::sample_type  val,
   output mgh_pkg::age_type     age,
   output logic                 oldest,
   output logic                 shift_out,
   output logic                 gt_out
);

   mgh_pkg::sample_type val_ff, val_in;
   mgh_pkg::age_type age_ff, age_in;

   always_comb begin
      oldest = (age_ff == mgh_pkg::AGE_MAX);
      shift_out = shift_left | oldest;
      gt_out = is_last | (val_ff > sample);
      val_in = val_ff;
      age_in = age_ff;
      if (ctrl.del && shift_out) begin
         val_in = right_val;
         age_in = right_age;
      end else if (ctrl.ins) begin
         if (gt_out) begin
            val_in = gt_left ? left_val : sample;
            age_in = gt_left ? left_age + mgh_pkg::age_type'(1) : '0;
         end else begin
            age_in = age_ff + mgh_pkg::age_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= reset_age;
      end else begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule

// ===== design/mgh_axis.sv =====
`include "assert_macros.svh"

module mgh_axis (
   input  logic                 clock,
   input  logic                 reset,
   input  mgh_pkg::ctrl_type    ctrl,
   input  mgh_pkg::coef_type    coef,
   input  mgh_pkg::sample_type  coord,
   output mgh_pkg::sample_type  result,
   output logic                 gated
);

   localparam int W = mgh_pkg::WINDOW;
   localparam int M = mgh_pkg::MEDIAN_IDX;

   mgh_pkg::sample_type vals [W];
   mgh_pkg::age_type ages [W];
   logic [W-1:0] oldest;
   logic [W-1:0] shift;
   logic [W-1:0] gt;

   mgh_pkg::sample_type sample_ff, sample_in;
   mgh_pkg::sample_type newest_ff, newest_in;
   mgh_pkg::sample_type med_ff, med_in;
   logic gated_ff, gated_in;
   logic signed [37:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   mgh_pkg::sample_type s_ff, s_in;
   mgh_pkg::sample_type last_ff, last_in;
   logic signed [17:0] trend_ff, trend_in;

   logic signed [18:0] pred;
   logic signed [17:0] diff, adiff;
   logic signed [16:0] step;
   logic [16:0] comp_a, comp_g;

   genvar i;
   generate
      for (i = 0; i < W; i++) begin : g_cell
         mgh_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .reset_age  (mgh_pkg::age_type'(i)),
            .is_last    (i == W - 1),
            .sample     (sample_ff),
            .left_val   ((i == 0) ? mgh_pkg::sample_type'(0) : vals[(i == 0) ? 0 : i - 1]),
            .left_age   ((i == 0) ? mgh_pkg::age_type'(0) : ages[(i == 0) ? 0 : i - 1]),
            .shift_left ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1]),
            .gt_left    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .right_val  (vals[(i == W - 1) ? i : i + 1]),
            .right_age  (ages[(i == W - 1) ? i : i + 1]),
            .val        (vals[i]),
            .age        (ages[i]),
            .oldest     (oldest[i]),
            .shift_out  (shift[i]),
            .gt_out     (gt[i])
         );
      end
   endgenerate

   always_comb begin
      sample_in = sample_ff;
      newest_in = newest_ff;
      if (ctrl.load) begin
         sample_in = coord[15] ? newest_ff : coord;
         newest_in = sample_in;
      end

      comp_a = 17'h10000 - {1'b0, coef.alpha};
      comp_g = 17'h10000 - {1'b0, coef.gamma};
      pred = 19'(last_ff) + 19'(trend_ff);
      diff = 18'(sample_ff) - 18'(vals[M]);
      adiff = diff[17] ? -diff : diff;

      med_in = med_ff;
      gated_in = gated_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      if (ctrl.mul1) begin
         med_in = vals[M];
         gated_in = (adiff > $signed({3'b0, coef.threshold}));
         prod_a_in = 38'($signed({1'b0, coef.alpha})) * 38'(sample_ff);
         prod_b_in = 38'($signed({1'b0, comp_a})) * 38'(pred);
      end

      step = 17'(s_ff) - 17'(last_ff);
      if (ctrl.mul2) begin
         prod_a_in = 38'($signed({1'b0, coef.gamma})) * 38'(step);
         prod_b_in = 38'($signed({1'b0, comp_g})) * 38'(trend_ff);
      end

      s_in = s_ff;
      if (ctrl.lvl) begin
         s_in = gated_ff ? med_ff
                         : mgh_pkg::sat16(mgh_pkg::round_q16(prod_a_ff + prod_b_ff));
      end

      last_in = last_ff;
      trend_in = trend_ff;
      if (ctrl.upd) begin
         last_in = s_ff;
         trend_in = mgh_pkg::sat18(mgh_pkg::round_q16(prod_a_ff + prod_b_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         last_ff <= '0;
         trend_ff <= '0;
      end else begin
         newest_ff <= newest_in;
         last_ff <= last_in;
         trend_ff <= trend_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      med_ff <= med_in;
      gated_ff <= gated_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      s_ff <= s_in;
   end

   assign result = s_ff;
   assign gated = gated_ff;

   `ASSERT_SAME(oldest_unique, ctrl.del, $onehot(oldest))
   `ASSERT_NEXT(sorted_after_insert, ctrl.ins, vals[M-1] <= vals[M])

endmodule

// ===== design/median_gated_holt_smoother.sv =====
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_x_in, req_y_in
// rsp       out        rsp_valid / rsp_stall  rsp_x_out, rsp_y_out, rsp_x_gated, rsp_y_gated
// csr       in         csr_write              csr_index, csr_data
//
// a request runs through these steps in order: accept, window delete, window insert,
// level multiply, level round, trend multiply, trend update; these run on the cell
// row and one pair of multipliers per axis
// the result sits in an output register; the next request is taken while it waits
// a stalled result holds the trend update step until the register frees
// reset (synchronous) clears the window to zero, trend and last result to zero
`include "assert_macros.svh"

module median_gated_holt_smoother (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_x_in,
   input  logic signed [15:0] req_y_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_x_out,
   output logic signed [15:0] rsp_y_out,
   output logic               rsp_x_gated,
   output logic               rsp_y_gated,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEL  = 3'd1;
   localparam logic [2:0] S_INS  = 3'd2;
   localparam logic [2:0] S_MUL1 = 3'd3;
   localparam logic [2:0] S_LVL  = 3'd4;
   localparam logic [2:0] S_MUL2 = 3'd5;
   localparam logic [2:0] S_UPD  = 3'd6;

   logic [2:0] state_ff, state_in;
   mgh_pkg::coef_type coef_ff, coef_in;
   mgh_pkg::ctrl_type ctrl;
   logic rsp_valid_ff, rsp_valid_in;
   mgh_pkg::sample_type x_ff, y_ff;
   logic xg_ff, yg_ff;
   mgh_pkg::sample_type x_res, y_res;
   logic x_gate, y_gate;

   always_comb begin
      ctrl.load = req_valid && (state_ff == S_IDLE);
      ctrl.del = (state_ff == S_DEL);
      ctrl.ins = (state_ff == S_INS);
      ctrl.mul1 = (state_ff == S_MUL1);
      ctrl.lvl = (state_ff == S_LVL);
      ctrl.mul2 = (state_ff == S_MUL2);
      ctrl.upd = (state_ff == S_UPD) && (!rsp_valid_ff || !rsp_stall);

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.load) begin
               state_in = S_DEL;
            end
         end
         S_DEL:  state_in = S_INS;
         S_INS:  state_in = S_MUL1;
         S_MUL1: state_in = S_LVL;
         S_LVL:  state_in = S_MUL2;
         S_MUL2: state_in = S_UPD;
         S_UPD: begin
            if (ctrl.upd) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (ctrl.upd) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      coef_in = coef_ff;
      if (csr_write) begin
         case (csr_index)
            mgh_pkg::REG_ALPHA:     coef_in.alpha = csr_data;
            mgh_pkg::REG_GAMMA:     coef_in.gamma = csr_data;
            mgh_pkg::REG_THRESHOLD: coef_in.threshold = csr_data[14:0];
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         coef_ff.alpha <= mgh_pkg::ALPHA_RESET;
         coef_ff.gamma <= mgh_pkg::GAMMA_RESET;
         coef_ff.threshold <= mgh_pkg::THRESHOLD_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd) begin
         x_ff <= x_res;
         y_ff <= y_res;
         xg_ff <= x_gate;
         yg_ff <= y_gate;
      end
   end

   mgh_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .coef   (coef_ff),
      .coord  (req_x_in),
      .result (x_res),
      .gated  (x_gate)
   );

   mgh_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .coef   (coef_ff),
      .coord  (req_y_in),
      .result (y_res),
      .gated  (y_gate)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = x_ff;
   assign rsp_y_out = y_ff;
   assign rsp_x_gated = xg_ff;
   assign rsp_y_gated = yg_ff;

   `ASSERT_NEXT(accept_starts_delete, req_valid && !req_stall, state_ff == S_DEL)
   `ASSERT_NEXT(update_gives_result, ctrl.upd, rsp_valid && state_ff == S_IDLE)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int N_WIN = mgh_pkg::WINDOW;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_x_in = '0;
   logic signed [15:0] req_y_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_x_out;
   logic signed [15:0] rsp_y_out;
   logic rsp_x_gated;
   logic rsp_y_gated;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   median_gated_holt_smoother uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic gx;
      logic gy;
   } point_type;

   typedef struct {
      int win[N_WIN];
      longint last;
      longint trend;
   } track_type;

   point_type smoothed_q[$];
   track_type trk_x, trk_y;
   int slot;
   longint k_alpha, k_gamma, k_thr;
   int errors = 0;
   longint cycles = 0;
   logic stall_mode = 1'b0;

   function automatic longint round16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int median_of(int w[N_WIN]);
      int t[N_WIN];
      int k;
      t = w;
      for (int i = 1; i < N_WIN; i++) begin
         k = t[i];
         for (int j = i - 1; j >= 0; j--) begin
            if (t[j] > k) begin
               t[j + 1] = t[j];
               t[j] = k;
            end
         end
      end
      return t[N_WIN / 2];
   endfunction

   function automatic longint axis_smooth(inout track_type a, input int v, input int prev,
                                          output logic gated);
      int sample, med;
      longint s, d;
      sample = v >= 0 ? v : a.win[prev];
      a.win[slot] = sample;
      med = median_of(a.win);
      d = sample - med;
      if (d < 0) d = -d;
      if (d > k_thr) begin
         s = med;
         gated = 1'b1;
      end else begin
         s = round16(k_alpha * sample + (65536 - k_alpha) * (a.last + a.trend));
         s = clip(s, -32768, 32767);
         gated = 1'b0;
      end
      a.trend = clip(round16(k_gamma * (s - a.last) + (65536 - k_gamma) * a.trend),
                     -131072, 131071);
      a.last = s;
      return s;
   endfunction

   function automatic void predict_point(logic signed [15:0] xi, logic signed [15:0] yi);
      point_type p;
      int prev;
      prev = slot == 0 ? N_WIN - 1 : slot - 1;
      p.x = 16'(axis_smooth(trk_x, int'(xi), prev, p.gx));
      p.y = 16'(axis_smooth(trk_y, int'(yi), prev, p.gy));
      slot = slot + 1 >= N_WIN ? 0 : slot + 1;
      smoothed_q = {smoothed_q, p};
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result checker
   always @(posedge clock) begin
      point_type p;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (smoothed_q.size() == 0) begin
            $error("unexpected result x=%0d y=%0d", rsp_x_out, rsp_y_out);
            errors++;
         end else begin
            p = smoothed_q.pop_front();
            if (rsp_x_out !== p.x) begin
               $error("x_out expected %0d actual %0d", p.x, rsp_x_out);
               errors++;
            end
            if (rsp_y_out !== p.y) begin
               $error("y_out expected %0d actual %0d", p.y, rsp_y_out);
               errors++;
            end
            if (rsp_x_gated !== p.gx) begin
               $error("x_gated expected %0b actual %0b", p.gx, rsp_x_gated);
               errors++;
            end
            if (rsp_y_gated !== p.gy) begin
               $error("y_gated expected %0b actual %0b", p.gy, rsp_y_gated);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (!stall_mode) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall) begin
         if ($urandom_range(0, 99) < 40) rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < (gap_len() > 5 ? 90 : 25));
      end
   end

   always @(posedge clock) begin
      if (cycles > 2000000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic send_point(logic signed [15:0] xi, logic signed [15:0] yi, bit idle);
      int g;
      g = idle ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_in <= xi;
      req_y_in <= yi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_point(xi, yi);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (smoothed_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         mgh_pkg::REG_ALPHA: k_alpha = val;
         mgh_pkg::REG_GAMMA: k_gamma = val;
         mgh_pkg::REG_THRESHOLD: k_thr = val & 16'h7fff;
         default: ;
      endcase
   endtask

   function automatic logic signed [15:0] rand_coord(int centre);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return -16'sd1 - 16'($urandom_range(0, 32767));
      if (r < 15) return 16'($urandom_range(0, 32767));
      if (r < 18) return 16'sh7fff;
      return 16'(clip(centre + $signed($urandom_range(0, 2000)) - 1000, 0, 32767));
   endfunction

   task automatic test_directed();
      logic signed [15:0] vals[10];
      vals = '{16'sh0000, -16'sd1, 16'sh7fff, 16'sh8000, 16'sd8192, 16'sd8193,
               16'sd16384, -16'sd1, 16'sh5555, 16'sh2aaa};
      // missing right after reset uses zero
      send_point(-16'sd5, 16'sh8000, 1'b0);
      for (int i = 0; i < 10; i++) send_point(vals[i], vals[9 - i], 1'b0);
      // threshold edge: inputs equal to the threshold value and just past it
      send_point(16'sd8192, 16'sd8193, 1'b0);
      for (int i = 0; i < 8; i++) send_point(16'sh7fff, 16'sd0, 1'b0);
      drain();
   endtask

   task automatic test_random_run(int n, int mid);
      int cx, cy;
      cx = mid;
      cy = 32767 - mid;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 49) == 0) begin
            cx = $urandom_range(0, 32767);
            cy = $urandom_range(0, 32767);
         end
         send_point(rand_coord(cx), rand_coord(cy), 1'b1);
      end
   endtask

   task automatic test_config_sweep();
      logic [15:0] al[5];
      logic [15:0] ga[5];
      logic [15:0] th[5];
      al = '{16'd0, 16'hffff, 16'd1, 16'd32768, mgh_pkg::ALPHA_RESET};
      ga = '{16'hffff, 16'd0, 16'd65535, 16'd12345, mgh_pkg::GAMMA_RESET};
      th = '{16'd0, 16'hffff, 16'h7fff, 16'd100, 16'(mgh_pkg::THRESHOLD_RESET)};
      for (int p = 0; p < 5; p++) begin
         write_reg(mgh_pkg::REG_ALPHA, al[p]);
         write_reg(mgh_pkg::REG_GAMMA, ga[p]);
         write_reg(mgh_pkg::REG_THRESHOLD, th[p]);
         // unused index is ignored
         write_reg(2'd3, 16'($urandom));
         stall_mode <= p[0];
         test_random_run(220, $urandom_range(0, 32767));
         // sender holds off until all results are back
         drain();
      end
   endtask

   task automatic test_random_values();
      stall_mode <= 1'b1;
      write_reg(mgh_pkg::REG_ALPHA, 16'($urandom));
      write_reg(mgh_pkg::REG_GAMMA, 16'($urandom));
      write_reg(mgh_pkg::REG_THRESHOLD, 16'($urandom_range(0, 32767)));
      for (int i = 0; i < 300; i++) send_point(16'($urandom), 16'($urandom), 1'b1);
      drain();
   endtask

   initial begin
      k_alpha = mgh_pkg::ALPHA_RESET;
      k_gamma = mgh_pkg::GAMMA_RESET;
      k_thr = mgh_pkg::THRESHOLD_RESET;
      slot = 0;
      for (int i = 0; i < N_WIN; i++) begin
         trk_x.win[i] = 0;
         trk_y.win[i] = 0;
      end
      trk_x.last = 0;
      trk_x.trend = 0;
      trk_y = trk_x;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_random_values();
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
